// File: rtl/core/nhcs_pkg.sv
`timescale 1ns / 1ps
// nhcs_pkg: constants, register codes and pipeline stage types for the
// Neo-Hookean Cauchy stress core. No dependencies.
package nhcs_pkg;

  localparam int unsigned NLANE      = 6;
  localparam int unsigned FW         = 32;
  localparam int unsigned SW         = 48;
  localparam int unsigned CBRT_STEPS = 21;
  localparam int unsigned PDIV_STEPS = 45;
  localparam int unsigned QA_STEPS   = 63;
  localparam int unsigned QB_STEPS   = 51;

  localparam logic [1:0] REG_SHEAR = 2'd0;
  localparam logic [1:0] REG_COMP  = 2'd1;
  localparam logic [1:0] REG_DIM   = 2'd2;

  localparam logic [31:0] SHEAR_RST = 32'd65536;
  localparam logic [31:0] COMP_RST  = 32'd65536;
  localparam logic        DIM_RST   = 1'b1;

  // ceil(2^40 / 3) split at bit 20
  localparam logic [18:0] RECIP3_LO = 19'd349526;
  localparam logic [18:0] RECIP3_HI = 19'd349525;

  localparam logic [40:0] ONE_Q28 = 41'd268435456;

  // Voigt order xx yy zz xy yz xz
  localparam int unsigned LROW [NLANE] = '{0, 1, 2, 0, 1, 0};
  localparam int unsigned LCOL [NLANE] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [39:0] rem;
    logic [62:0] quo;
    logic        sat;
  } qa_lane_t;

  typedef struct packed {
    qa_lane_t [NLANE-1:0] lane;
    logic [NLANE-1:0]     neg;
    logic                 inv;
    logic [39:0]          jq;
    logic [59:0]          cn;
    logic [19:0]          cy;
    logic [31:0]          prem;
    logic [44:0]          pq;
    logic                 pneg;
  } qa_t;

  typedef struct packed {
    logic [NLANE-1:0][62:0] t;
    logic [NLANE-1:0]       neg;
    logic                   inv;
    logic [39:0]            r2;
    logic [45:0]            p;
  } qx_t;

  typedef struct packed {
    logic [39:0] rem;
    logic [50:0] quo;
    logic        sat;
  } qb_lane_t;

  typedef struct packed {
    qb_lane_t [NLANE-1:0] lane;
    logic [NLANE-1:0]     neg;
    logic                 inv;
    logic [39:0]          r2;
    logic [45:0]          p;
  } qb_t;

endpackage

// File: rtl/core/neo_hookean_cauchy_stress_top.sv
`timescale 1ns / 1ps
// neo_hookean_cauchy_stress_top: compressible Neo-Hookean Cauchy stress pipeline
// with stream ports and an APB register port. Uses nhcs_pkg.

// One deformation gradient enters per clock while s_tready is high, and its six
// Voigt stresses leave at the output; throughput is one item per cycle whenever
// the output side takes results. Most of the pipeline is the two quotient chains:
// 63 one-bit steps for N*2^24/J, then 51 one-bit steps for the division by
// (J^(1/3))^2, each step a register stage; the cube root and the volumetric term
// are worked out bit by bit in parallel with the first chain. A stalled output
// holds the whole pipeline. Items with det F <= 0 return zero stress with tuser
// set. Registers (shear at 0x0, compressibility at 0x4, 3D mode at 0x8) must be
// changed only while no item is in flight; the block itself does not enforce it.
module neo_hookean_cauchy_stress_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // f_xx f_xy f_xz f_yx f_yy f_yz f_zx f_zy f_zz, 32 bits each
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [9*nhcs_pkg::FW-1:0]    s_tdata,
  // sigma_xx sigma_yy sigma_zz sigma_xy sigma_yz sigma_xz, 48 bits each
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [6*nhcs_pkg::SW-1:0]    m_tdata,
  // element_inverted
  output logic                         m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import nhcs_pkg::*;

  // configuration
  logic [31:0] shear_q, comp_q, d1;
  logic        dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_q <= SHEAR_RST;
      comp_q  <= COMP_RST;
      dim_q   <= DIM_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SHEAR: shear_q <= pwdata;
        REG_COMP:  comp_q  <= pwdata;
        REG_DIM:   dim_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SHEAR: prdata = shear_q;
      REG_COMP:  prdata = comp_q;
      REG_DIM:   prdata = {31'b0, dim_q};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign d1     = (comp_q == '0) ? 32'd1 : comp_q;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front stages
  logic signed [FW-1:0] fin     [3][3];
  logic signed [63:0]   bprod   [NLANE][3];
  logic signed [63:0]   cprod   [NLANE];
  logic signed [35:0]   s1_bp_d [NLANE][3];
  logic signed [35:0]   s1_bp_q [NLANE][3];
  logic signed [31:0]   s1_cp_d [NLANE];
  logic signed [31:0]   s1_cp_q [NLANE];
  logic signed [31:0]   s1_f0_d [3];
  logic signed [31:0]   s1_f0_q [3];
  logic signed [37:0]   s2_b_d  [NLANE];
  logic signed [37:0]   s2_b_q  [NLANE];
  logic signed [32:0]   s2_c_d  [3];
  logic signed [32:0]   s2_c_q  [3];
  logic signed [31:0]   s2_f0_q [3];
  logic signed [64:0]   jprod   [3];
  logic signed [39:0]   s3_jp_d [3];
  logic signed [39:0]   s3_jp_q [3];
  logic signed [39:0]   i1sum;
  logic [37:0]          s3_i1_d, s3_i1_q;
  logic signed [37:0]   s3_b_q  [NLANE];
  logic [41:0]          jqsum;
  logic [40:0]          s4_jq_d, s4_jq_q;
  logic [56:0]          s4_ml_d, s4_ml_q, s4_mh_d, s4_mh_q;
  logic signed [37:0]   s4_b_q  [NLANE];
  logic [77:0]          msum;
  logic [35:0]          s5_m_d, s5_m_q;
  logic [40:0]          s5_jq_q;
  logic signed [37:0]   s5_b_q  [NLANE];
  logic [38:0]          dvd     [NLANE];
  logic [30:0]          dsh     [NLANE];
  logic [30:0]          dabs    [NLANE];
  logic [27:0]          s6_mag_d [NLANE];
  logic [27:0]          s6_mag_q [NLANE];
  logic [NLANE-1:0]     s6_neg_d, s6_neg_q;
  logic                 s6_inv_d, s6_inv_q;
  logic [39:0]          s6_jq_d, s6_jq_q;
  logic [60:0]          s7_n_d  [NLANE];
  logic [60:0]          s7_n_q  [NLANE];
  logic [NLANE-1:0]     s7_neg_q;
  logic                 s7_inv_q;
  logic [39:0]          s7_jq_q;
  logic [7:1]           vf_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        fin[r][c] = s_tdata[FW*(3*r+c) +: FW];
      end
    end
    for (int e = 0; e < NLANE; e++) begin
      for (int k = 0; k < 3; k++) begin
        bprod[e][k]   = 64'(fin[LROW[e]][k]) * 64'(fin[LCOL[e]][k]);
        s1_bp_d[e][k] = bprod[e][k][63:28];
      end
    end
    cprod[0] = 64'(fin[1][1]) * 64'(fin[2][2]);
    cprod[1] = 64'(fin[1][2]) * 64'(fin[2][1]);
    cprod[2] = 64'(fin[1][0]) * 64'(fin[2][2]);
    cprod[3] = 64'(fin[1][2]) * 64'(fin[2][0]);
    cprod[4] = 64'(fin[1][0]) * 64'(fin[2][1]);
    cprod[5] = 64'(fin[1][1]) * 64'(fin[2][0]);
    for (int i = 0; i < NLANE; i++) begin
      s1_cp_d[i] = cprod[i][63:32];
    end
    for (int k = 0; k < 3; k++) begin
      s1_f0_d[k] = fin[0][k];
    end

    for (int e = 0; e < NLANE; e++) begin
      s2_b_d[e] = 38'(s1_bp_q[e][0]) + 38'(s1_bp_q[e][1]) + 38'(s1_bp_q[e][2]);
    end
    for (int k = 0; k < 3; k++) begin
      s2_c_d[k] = 33'(s1_cp_q[2*k]) - 33'(s1_cp_q[2*k+1]);
    end

    for (int k = 0; k < 3; k++) begin
      jprod[k]   = 65'(s2_f0_q[k]) * 65'(s2_c_q[k]);
      s3_jp_d[k] = jprod[k][63:24];
    end
    i1sum   = 40'(s2_b_q[0]) + 40'(s2_b_q[1]) + 40'(s2_b_q[2]);
    s3_i1_d = i1sum[37:0];

    jqsum   = 42'(s3_jp_q[0]) - 42'(s3_jp_q[1]) + 42'(s3_jp_q[2]);
    s4_jq_d = jqsum[40:0];
    s4_ml_d = 57'(s3_i1_q) * 57'(RECIP3_LO);
    s4_mh_d = 57'(s3_i1_q) * 57'(RECIP3_HI);

    msum   = 78'({s4_mh_q, 20'b0}) + 78'(s4_ml_q);
    s5_m_d = msum[75:40];

    for (int e = 0; e < NLANE; e++) begin
      if (e < 3) begin
        dvd[e] = 39'(s5_b_q[e]) - 39'(s5_m_q);
      end else begin
        dvd[e] = 39'(s5_b_q[e]);
      end
      dsh[e]         = dvd[e][38:8];
      dabs[e]        = dsh[e][30] ? (~dsh[e] + 31'd1) : dsh[e];
      s6_mag_d[e]    = dabs[e][27:0];
      s6_neg_d[e]    = dsh[e][30];
    end
    s6_inv_d = s5_jq_q[40] || (s5_jq_q == '0);
    s6_jq_d  = s5_jq_q[39:0];

    for (int e = 0; e < NLANE; e++) begin
      s7_n_d[e] = 61'({shear_q, 1'b0}) * 61'(s6_mag_q[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bp_q  <= s1_bp_d;
      s1_cp_q  <= s1_cp_d;
      s1_f0_q  <= s1_f0_d;
      s2_b_q   <= s2_b_d;
      s2_c_q   <= s2_c_d;
      s2_f0_q  <= s1_f0_q;
      s3_jp_q  <= s3_jp_d;
      s3_i1_q  <= s3_i1_d;
      s3_b_q   <= s2_b_q;
      s4_jq_q  <= s4_jq_d;
      s4_ml_q  <= s4_ml_d;
      s4_mh_q  <= s4_mh_d;
      s4_b_q   <= s3_b_q;
      s5_m_q   <= s5_m_d;
      s5_jq_q  <= s4_jq_q;
      s5_b_q   <= s4_b_q;
      s6_mag_q <= s6_mag_d;
      s6_neg_q <= s6_neg_d;
      s6_inv_q <= s6_inv_d;
      s6_jq_q  <= s6_jq_d;
      s7_n_q   <= s7_n_d;
      s7_neg_q <= s6_neg_q;
      s7_inv_q <= s6_inv_q;
      s7_jq_q  <= s6_jq_q;
    end
  end

  // first quotient chain, cube root and volumetric divide
  qa_t              a_d [QA_STEPS+1];
  qa_t              a_q [QA_STEPS+1];
  logic [QA_STEPS:0] va_q;
  logic [40:0]      pdiff, pabs;

  always_comb begin
    for (int e = 0; e < NLANE; e++) begin
      a_d[0].lane[e].rem = {18'b0, s7_n_q[e][60:39]};
      a_d[0].lane[e].quo = {s7_n_q[e][38:0], 24'b0};
      a_d[0].lane[e].sat = 40'(s7_n_q[e][60:39]) >= s7_jq_q;
    end
    pdiff         = {1'b0, s7_jq_q} - ONE_Q28;
    pabs          = pdiff[40] ? (~pdiff + 41'd1) : pdiff;
    a_d[0].neg    = s7_neg_q;
    a_d[0].inv    = s7_inv_q;
    a_d[0].jq     = s7_jq_q;
    a_d[0].cn     = {s7_jq_q, 20'b0};
    a_d[0].cy     = '0;
    a_d[0].prem   = '0;
    a_d[0].pq     = {pabs[39:0], 5'b0};
    a_d[0].pneg   = pdiff[40];
  end

  for (genvar i = 0; i < QA_STEPS; i++) begin : g_qa
    logic [40:0] tmp [NLANE];
    logic [59:0] cn_nx;
    logic [19:0] cy_nx;
    logic [31:0] prem_nx;
    logic [44:0] pq_nx;

    if (i < CBRT_STEPS) begin : g_cb
      localparam int unsigned SH = 60 - 3*i;
      logic [19:0] y2;
      logic [40:0] pp;
      logic [42:0] bb;
      logic [63:0] nsh, bsh;
      always_comb begin
        y2  = {a_q[i].cy[18:0], 1'b0};
        pp  = 41'(y2) * 41'(y2 + 20'd1);
        bb  = {1'b0, pp, 1'b0} + {2'b0, pp} + 43'd1;
        nsh = 64'(a_q[i].cn) >> SH;
        bsh = 64'(bb) << SH;
        if (nsh >= 64'(bb)) begin
          cn_nx = a_q[i].cn - bsh[59:0];
          cy_nx = y2 | 20'd1;
        end else begin
          cn_nx = a_q[i].cn;
          cy_nx = y2;
        end
      end
    end else begin : g_cbh
      assign cn_nx = a_q[i].cn;
      assign cy_nx = a_q[i].cy;
    end

    if (i < PDIV_STEPS) begin : g_pd
      logic [32:0] ptmp;
      always_comb begin
        ptmp = {a_q[i].prem, a_q[i].pq[44]};
        if (ptmp >= {1'b0, d1}) begin
          prem_nx = 32'(ptmp - {1'b0, d1});
          pq_nx   = {a_q[i].pq[43:0], 1'b1};
        end else begin
          prem_nx = ptmp[31:0];
          pq_nx   = {a_q[i].pq[43:0], 1'b0};
        end
      end
    end else begin : g_pdh
      assign prem_nx = a_q[i].prem;
      assign pq_nx   = a_q[i].pq;
    end

    always_comb begin
      a_d[i+1] = a_q[i];
      for (int e = 0; e < NLANE; e++) begin
        tmp[e] = {a_q[i].lane[e].rem, a_q[i].lane[e].quo[62]};
        if (tmp[e] >= 41'(a_q[i].jq)) begin
          a_d[i+1].lane[e].rem = 40'(tmp[e] - 41'(a_q[i].jq));
          a_d[i+1].lane[e].quo = {a_q[i].lane[e].quo[61:0], 1'b1};
        end else begin
          a_d[i+1].lane[e].rem = tmp[e][39:0];
          a_d[i+1].lane[e].quo = {a_q[i].lane[e].quo[61:0], 1'b0};
        end
      end
      a_d[i+1].cn   = cn_nx;
      a_d[i+1].cy   = cy_nx;
      a_d[i+1].prem = prem_nx;
      a_d[i+1].pq   = pq_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  // clamp, r^2 and signed volumetric term
  qx_t         x_d, x_q;
  logic        vx_q;
  logic [45:0] pq46;

  always_comb begin
    for (int e = 0; e < NLANE; e++) begin
      if (a_q[QA_STEPS].lane[e].sat ||
          (a_q[QA_STEPS].lane[e].quo[62] && |a_q[QA_STEPS].lane[e].quo[61:0])) begin
        x_d.t[e] = {1'b1, 62'b0};
      end else begin
        x_d.t[e] = a_q[QA_STEPS].lane[e].quo;
      end
    end
    pq46    = {1'b0, a_q[QA_STEPS].pq};
    x_d.p   = a_q[QA_STEPS].pneg ? (~pq46 + 46'd1) : pq46;
    x_d.r2  = 40'(a_q[QA_STEPS].cy) * 40'(a_q[QA_STEPS].cy);
    x_d.neg = a_q[QA_STEPS].neg;
    x_d.inv = a_q[QA_STEPS].inv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= x_d;
    end
  end

  // second quotient chain
  qb_t               b_d [QB_STEPS+1];
  qb_t               b_q [QB_STEPS+1];
  logic [QB_STEPS:0] vb_q;

  always_comb begin
    for (int e = 0; e < NLANE; e++) begin
      b_d[0].lane[e].rem = {12'b0, x_q.t[e][62:35]};
      b_d[0].lane[e].quo = {x_q.t[e][34:0], 16'b0};
      b_d[0].lane[e].sat = 40'(x_q.t[e][62:35]) >= x_q.r2;
    end
    b_d[0].neg = x_q.neg;
    b_d[0].inv = x_q.inv;
    b_d[0].r2  = x_q.r2;
    b_d[0].p   = x_q.p;
  end

  for (genvar i = 0; i < QB_STEPS; i++) begin : g_qb
    logic [40:0] tmp [NLANE];
    always_comb begin
      b_d[i+1] = b_q[i];
      for (int e = 0; e < NLANE; e++) begin
        tmp[e] = {b_q[i].lane[e].rem, b_q[i].lane[e].quo[50]};
        if (tmp[e] >= 41'(b_q[i].r2)) begin
          b_d[i+1].lane[e].rem = 40'(tmp[e] - 41'(b_q[i].r2));
          b_d[i+1].lane[e].quo = {b_q[i].lane[e].quo[49:0], 1'b1};
        end else begin
          b_d[i+1].lane[e].rem = tmp[e][39:0];
          b_d[i+1].lane[e].quo = {b_q[i].lane[e].quo[49:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= b_d;
    end
  end

  // sign, volumetric add, zeroing and saturation
  logic [50:0]          sv   [NLANE];
  logic signed [52:0]   vv   [NLANE];
  logic [6*SW-1:0]      out_d, out_q;
  logic                 inv_q;

  always_comb begin
    out_d = '0;
    for (int e = 0; e < NLANE; e++) begin
      if (b_q[QB_STEPS].lane[e].sat ||
          (b_q[QB_STEPS].lane[e].quo[50] && |b_q[QB_STEPS].lane[e].quo[49:0])) begin
        sv[e] = {1'b1, 50'b0};
      end else begin
        sv[e] = b_q[QB_STEPS].lane[e].quo;
      end
      vv[e] = b_q[QB_STEPS].neg[e] ? -$signed(53'(sv[e])) : $signed(53'(sv[e]));
      if (e < 3) begin
        vv[e] = vv[e] + $signed({{7{b_q[QB_STEPS].p[45]}}, b_q[QB_STEPS].p});
      end
      if (b_q[QB_STEPS].inv || (e >= 4 && !dim_q)) begin
        out_d[SW*e +: SW] = '0;
      end else if (vv[e][52:47] != {6{vv[e][52]}}) begin
        out_d[SW*e +: SW] = vv[e][52] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end else begin
        out_d[SW*e +: SW] = vv[e][47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
      inv_q <= b_q[QB_STEPS].inv;
    end
  end

  logic ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
      va_q <= '0;
      vx_q <= 1'b0;
      vb_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      vf_q <= {vf_q[6:1], s_tvalid};
      va_q <= {va_q[QA_STEPS-1:0], vf_q[7]};
      vx_q <= va_q[QA_STEPS];
      vb_q <= {vb_q[QB_STEPS-1:0], vx_q};
      ov_q <= vb_q[QB_STEPS];
    end
  end

  assign m_tvalid = ov_q;
  assign m_tdata  = out_q;
  assign m_tuser  = inv_q;

`ifndef SYNTHESIS
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("inverted item carries nonzero stress");

  a_plane_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !dim_q) |-> (m_tdata[6*SW-1:4*SW] == '0))
    else $error("plane strain item carries out-of-plane shear");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> ($stable(va_q) && $stable(vb_q) && $stable(vf_q)))
    else $error("pipeline valid bits moved during stall");
`endif

endmodule
